FILE: design/pffl_pkg.sv
// Shared types, codes and constants of the page frame free-list allocator.
package pffl_pkg;

  // Field widths fixed by the request and response formats
  localparam int KIND_W  = 3;
  localparam int FRAME_W = 10;
  localparam int CNT_W   = 11;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE  = 1'b1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] FRAME_COUNT_RST = 11'd1024;
  localparam logic [CFG_W-1:0] FIRST_FREE_RST  = 11'd1;

  // Request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC_USER   = 3'd0,
    KIND_ALLOC_KERNEL = 3'd1,
    KIND_FREE_USER    = 3'd2,
    KIND_FREE_KERNEL  = 3'd3,
    KIND_CHECK_USER   = 3'd4,
    KIND_INIT         = 3'd5
  } kind_e;

  // Per-frame status held in the status store
  typedef enum logic [1:0] {
    FS_NULL   = 2'd0,
    FS_FREE   = 2'd1,
    FS_KERNEL = 2'd2,
    FS_USER   = 2'd3
  } fstat_e;

  // Result status codes
  typedef enum logic [1:0] {
    RS_OK           = 2'd0,
    RS_NO_FREE      = 2'd1,
    RS_WRONG_STATUS = 2'd2,
    RS_RANGE        = 2'd3
  } rstat_e;

  // Request payload
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [FRAME_W-1:0] frame;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [FRAME_W-1:0] alloc_frame;
    logic [1:0]         status;
    logic               is_user;
    logic [CNT_W-1:0]   free_count;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic init_step;
    logic exec;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic walk_last;
    logic in_init;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: design/pffl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pffl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/pffl_dp.sv
// Datapath: config registers, list head, free counter, stores and response register.
module pffl_dp #(
  parameter int FRAMES = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pffl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pffl_pkg::CFG_W-1:0]        cfg_data_i,
  input  pffl_pkg::req_t                    req_i,
  input  logic                              rsp_ready_i,
  output pffl_pkg::rsp_t                    rsp_o,
  output logic                              rsp_valid_o,
  input  pffl_pkg::cmd_t                    cmd_i,
  output pffl_pkg::dp_stat_t                stat_o
);

  localparam int AW = $clog2(FRAMES);
  localparam int CW = pffl_pkg::CNT_W;
  localparam int FW = pffl_pkg::FRAME_W;
  localparam int CAP_I = (FRAMES < 2047) ? FRAMES : 2047;
  localparam logic [CW-1:0] FRAMES_CAP = CW'(CAP_I);
  localparam logic [AW-1:0] LAST_ADDR = AW'(FRAMES - 1);

  logic [pffl_pkg::CFG_W-1:0] frame_count_q, first_free_q;
  pffl_pkg::req_t req_q;
  logic [AW-1:0]  head_q, head_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  walk_q, walk_d;
  logic [AW-1:0]  clr_q;
  pffl_pkg::rsp_t out_q, out_d;
  logic           out_valid_q;
  logic [CW-1:0]  active;
  logic           out_free;
  logic           frame_ok;
  logic           push;

  logic           stat_we, link_we, rd_en;
  logic [AW-1:0]  stat_waddr, link_waddr, stat_raddr;
  logic [1:0]     stat_wdata, stat_rdata;
  logic [AW-1:0]  link_wdata, link_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= pffl_pkg::FRAME_COUNT_RST;
      first_free_q  <= pffl_pkg::FIRST_FREE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pffl_pkg::CFG_FRAME_COUNT: frame_count_q <= cfg_data_i;
        pffl_pkg::CFG_FIRST_FREE:  first_free_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Active frame count is the configured count capped at the store depth
  assign active   = (frame_count_q < FRAMES_CAP) ? frame_count_q : FRAMES_CAP;
  assign out_free = !out_valid_q || rsp_ready_i;
  assign frame_ok = ({1'b0, req_q.frame} < active);
  assign push     = (walk_q >= first_free_q) && (walk_q < active);

  // Read both stores on accept: link at the head, status at the request frame
  assign rd_en      = cmd_i.accept;
  assign stat_raddr = AW'(req_i.frame);

  // Next state of head, counter, walk index, store writes and response
  always_comb begin
    head_d     = head_q;
    cnt_d      = cnt_q;
    walk_d     = walk_q;
    stat_we    = 1'b0;
    stat_waddr = AW'(req_q.frame);
    stat_wdata = pffl_pkg::FS_FREE;
    link_we    = 1'b0;
    link_waddr = AW'(req_q.frame);
    link_wdata = head_q;
    out_d      = '0;

    if (cmd_i.clear_step) begin
      stat_we    = 1'b1;
      stat_waddr = clr_q;
      stat_wdata = pffl_pkg::FS_NULL;
    end else if (cmd_i.accept) begin
      // Init starts from an empty list at the top of the active range
      if (req_i.kind == pffl_pkg::KIND_INIT) begin
        head_d = '0;
        cnt_d  = '0;
        walk_d = (active == '0) ? '0 : active - CW'(1);
      end
    end else if (cmd_i.init_step) begin
      stat_we    = 1'b1;
      stat_waddr = AW'(walk_q);
      link_waddr = AW'(walk_q);
      if (walk_q == '0) begin
        stat_wdata = pffl_pkg::FS_NULL;
      end else if (walk_q >= first_free_q) begin
        stat_wdata = pffl_pkg::FS_FREE;
      end else begin
        stat_wdata = pffl_pkg::FS_KERNEL;
      end
      if (push) begin
        link_we = 1'b1;
        head_d  = AW'(walk_q);
        cnt_d   = cnt_q + CW'(1);
      end
      if (walk_q != '0) begin
        walk_d = walk_q - CW'(1);
      end
    end else if (cmd_i.exec) begin
      out_d.status = pffl_pkg::RS_OK;
      case (req_q.kind)
        pffl_pkg::KIND_ALLOC_USER, pffl_pkg::KIND_ALLOC_KERNEL: begin
          if (cnt_q == '0) begin
            out_d.status = pffl_pkg::RS_NO_FREE;
          end else begin
            out_d.alloc_frame = FW'(head_q);
            stat_we    = 1'b1;
            stat_waddr = head_q;
            stat_wdata = (req_q.kind == pffl_pkg::KIND_ALLOC_USER) ?
                         pffl_pkg::FS_USER : pffl_pkg::FS_KERNEL;
            head_d     = link_rdata;
            cnt_d      = cnt_q - CW'(1);
          end
        end
        pffl_pkg::KIND_FREE_USER, pffl_pkg::KIND_FREE_KERNEL: begin
          if (!frame_ok) begin
            out_d.status = pffl_pkg::RS_RANGE;
          end else if (stat_rdata != ((req_q.kind == pffl_pkg::KIND_FREE_USER) ?
                                      pffl_pkg::FS_USER : pffl_pkg::FS_KERNEL)) begin
            out_d.status = pffl_pkg::RS_WRONG_STATUS;
          end else begin
            stat_we = 1'b1;
            link_we = 1'b1;
            head_d  = AW'(req_q.frame);
            cnt_d   = cnt_q + CW'(1);
          end
        end
        pffl_pkg::KIND_CHECK_USER: begin
          if (!frame_ok) begin
            out_d.status = pffl_pkg::RS_RANGE;
          end else begin
            out_d.is_user = (stat_rdata == pffl_pkg::FS_USER);
          end
        end
        default: ;
      endcase
      out_d.free_count = cnt_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      walk_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      walk_q <= walk_d;
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and response payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      out_q <= out_d;
    end
  end

  // Frame status store
  pffl_ram #(
    .W(2),
    .D(FRAMES)
  ) u_stat_ram (
    .clk_i  (clk_i),
    .we_i   (stat_we),
    .waddr_i(stat_waddr),
    .wdata_i(stat_wdata),
    .re_i   (rd_en),
    .raddr_i(stat_raddr),
    .rdata_o(stat_rdata)
  );

  // Next-link store
  pffl_ram #(
    .W(AW),
    .D(FRAMES)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .re_i   (rd_en),
    .raddr_i(head_q),
    .rdata_o(link_rdata)
  );

  assign rsp_o       = out_q;
  assign rsp_valid_o = out_valid_q;

  assign stat_o.clr_last  = (clr_q == LAST_ADDR);
  assign stat_o.walk_last = (walk_q == '0);
  assign stat_o.in_init   = (req_i.kind == pffl_pkg::KIND_INIT);
  assign stat_o.out_free  = out_free;

  // A response is loaded only when the output register can take it
  a_exec_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> out_free)
    else $error("response loaded over an untaken response");

  // Allocating from an empty list leaves the head and count alone
  a_empty_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && cnt_q == '0 &&
     (req_q.kind == pffl_pkg::KIND_ALLOC_USER ||
      req_q.kind == pffl_pkg::KIND_ALLOC_KERNEL)) |=> ($stable(head_q) && $stable(cnt_q)))
    else $error("empty-list allocate changed the list");

  // The init walk moves down one frame a step
  a_walk_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.init_step && walk_q != '0) |=> (walk_q == $past(walk_q) - CW'(1)))
    else $error("init walk skipped a frame");

endmodule

FILE: design/pffl_ctrl.sv
// Controller: sequences clear pass, request accept, init walk and response load.
module pffl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  pffl_pkg::dp_stat_t stat_i,
  output pffl_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_INIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = stat_i.in_init ? S_INIT : S_EXEC;
        end
      end
      S_INIT: begin
        cmd_o.init_step = 1'b1;
        if (stat_i.walk_last) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // At most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.clear_step, cmd_o.accept, cmd_o.init_step, cmd_o.exec}))
    else $error("conflicting datapath commands");

  // The clearing pass runs once after reset only
  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLEAR) |=> (state_q != S_CLEAR))
    else $error("clearing pass restarted");

endmodule

FILE: design/page_frame_free_list_allocator.sv
// Top level of the page frame free-list allocator.
//
//   channel   direction  handshake                    payload
//   request   in         req_valid_i / req_ready_o    req_i (kind, frame)
//   response  out        rsp_valid_o / rsp_ready_i    rsp_o (alloc_frame, status, is_user, free_count)
//   config    in         cfg_we_i                     cfg_idx_i, cfg_data_i
//
// Allocate, free, check: accept with store read, then update.
// Init: accept, a walk with one status store write per frame walked (plus a link write per free frame), then update.
// After reset a clearing pass writes null status to all FRAMES entries;
// requests wait for it, config writes do not.
// A held response stalls the update step, and no further request is accepted until that update has run.
module page_frame_free_list_allocator #(
  parameter int FRAMES = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pffl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pffl_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  pffl_pkg::req_t                 req_i,
  output logic                           rsp_valid_o,
  input  logic                           rsp_ready_i,
  output pffl_pkg::rsp_t                 rsp_o
);

  pffl_pkg::cmd_t     cmd;
  pffl_pkg::dp_stat_t stat;

  pffl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pffl_dp #(
    .FRAMES(FRAMES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o),
    .rsp_valid_o(rsp_valid_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule
